// ===== rtl/core/gcr_pkg.sv =====
// shared types, constants and helpers of the generalized camera residual block
// used by every module under rtl/core; depends on nothing
package gcr_pkg;

   localparam int RIG_CAMERAS_DEF = 8;
   localparam int ROW_COUNT       = 3;

   localparam logic [1:0] OP_LOAD_POSE = 2'd0;
   localparam logic [1:0] OP_LOAD_CAM  = 2'd1;
   localparam logic [1:0] OP_EVALUATE  = 2'd2;

   localparam logic [31:0] RES_MAX = 32'hFFFF_FFFF;
   localparam logic [16:0] ONE_Q16 = 17'h1_0000;

   typedef enum logic [1:0] {
      KIND_POSE,
      KIND_CAM,
      KIND_EVAL,
      KIND_NOCAM
   } kind_type;

   typedef logic [3:0][31:0] row_type;

   typedef struct packed {
      kind_type    kind;
      logic [2:0]  cam;
      logic [1:0]  row;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [31:0] e;
   } item_type;

   typedef struct packed {
      logic        start;
      logic        sqrt;
      logic [63:0] num;
      logic [32:0] den;
   } iter_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } iter_rsp_type;

   function automatic logic [31:0] sat32(input logic signed [49:0] v);
      logic [31:0] r;
      if ((&v[49:31]) || !(|v[49:31])) begin
         r = v[31:0];
      end else if (v[49]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/generalized_camera_residual.sv =====
// a load passes through the queue into the pose or camera store and gives no result
// evaluate: six matrix rows on one multiplier (four behind the camera, none for a camera
// out of range), then divides in reprojection mode or square roots and divides in cosine
// mode on the shared iterative unit; rsp_stall can hold the finished result
// evaluates run one at a time; loads one per cycle while the sequencer is idle; a 2-entry queue buffers
// reset clears control, the pose to zero and error_mode to 1; camera transforms undefined
module generalized_camera_residual import gcr_pkg::*; #(
   parameter int RIG_CAMERAS = RIG_CAMERAS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [2:0]  req_camera_index,
   input  logic [1:0]  req_row_index,
   input  logic [31:0] req_value_a,
   input  logic [31:0] req_value_b,
   input  logic [31:0] req_value_c,
   input  logic [31:0] req_value_d,
   input  logic [31:0] req_value_e,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_residual,
   output logic        rsp_behind_camera,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_error_mode
);

   logic         error_mode_ff, error_mode_in;
   logic         q_valid, q_pop;
   item_type     q_item;
   iter_req_type it_req;
   iter_rsp_type it_rsp;

   assign csr_ready     = 1'b1;
   assign error_mode_in = (csr_valid && csr_ready) ? csr_error_mode : error_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         error_mode_ff <= 1'b1;
      end else begin
         error_mode_ff <= error_mode_in;
      end
   end

   gcr_front #(.RIG_CAMERAS(RIG_CAMERAS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_camera_index (req_camera_index),
      .req_row_index    (req_row_index),
      .req_value_a      (req_value_a),
      .req_value_b      (req_value_b),
      .req_value_c      (req_value_c),
      .req_value_d      (req_value_d),
      .req_value_e      (req_value_e),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop)
   );

   gcr_iter u_iter (
      .clock  (clock),
      .reset  (reset),
      .it_req (it_req),
      .it_rsp (it_rsp)
   );

   gcr_back #(.RIG_CAMERAS(RIG_CAMERAS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .error_mode        (error_mode_ff),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .it_req            (it_req),
      .it_rsp            (it_rsp),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_residual      (rsp_residual),
      .rsp_behind_camera (rsp_behind_camera)
   );

endmodule

// ===== rtl/core/gcr_front.sv =====
// front end: accepts request transfers, drops invalid ones, classifies the rest and queues them
// depends on gcr_pkg
module gcr_front import gcr_pkg::*; #(
   parameter int RIG_CAMERAS = RIG_CAMERAS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [2:0]  req_camera_index,
   input  logic [1:0]  req_row_index,
   input  logic [31:0] req_value_a,
   input  logic [31:0] req_value_b,
   input  logic [31:0] req_value_c,
   input  logic [31:0] req_value_d,
   input  logic [31:0] req_value_e,
   output logic        q_valid,
   output item_type    q_item,
   input  logic        q_pop
);

   logic [1:0] count_ff, count_in;
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   item_type   slot_ff [2];
   item_type   item_in;
   logic       accept, keep, push, cam_ok, row_ok;

   always_comb begin
      accept  = req_valid && !req_stall;
      cam_ok  = 32'(req_camera_index) < RIG_CAMERAS;
      row_ok  = 32'(req_row_index) < ROW_COUNT;
      item_in = '{kind: KIND_POSE, cam: req_camera_index, row: req_row_index,
                  a: req_value_a, b: req_value_b, c: req_value_c,
                  d: req_value_d, e: req_value_e};
      keep = 1'b0;
      case (req_opcode)
         OP_LOAD_POSE: begin
            keep = row_ok;
            item_in.kind = KIND_POSE;
         end
         OP_LOAD_CAM: begin
            keep = row_ok && cam_ok;
            item_in.kind = KIND_CAM;
         end
         OP_EVALUATE: begin
            keep = 1'b1;
            item_in.kind = cam_ok ? KIND_EVAL : KIND_NOCAM;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
      push     = accept && keep;
      count_in = count_ff + 2'(push) - 2'(q_pop);
      wr_in    = wr_ff ^ push;
      rd_in    = rd_ff ^ q_pop;
   end

   assign req_stall = (count_ff == 2'd2);
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= item_in;
      end
   end

`ifndef SYNTHESIS
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue count out of range");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) |-> !push)
      else $error("transfer taken while queue full");
`endif

endmodule

// ===== rtl/core/gcr_iter.sv =====
// shared iterative unit: 64-step restoring divide or 32-step integer square root
// depends on gcr_pkg
module gcr_iter import gcr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  iter_req_type it_req,
   output iter_rsp_type it_rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        sqrt_ff, sqrt_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] num_ff, num_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] bit_ff, bit_in;
   logic [32:0] rem_ff, rem_in;
   logic [32:0] den_ff, den_in;
   logic [33:0] shifted;
   logic [34:0] diff;
   logic [64:0] trial;
   logic        ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      sqrt_in = sqrt_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      bit_in  = bit_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      shifted = {rem_ff, num_ff[63]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      trial   = {1'b0, quo_ff} + {1'b0, bit_ff};
      ge      = 1'b0;
      if (it_req.start) begin
         busy_in = 1'b1;
         sqrt_in = it_req.sqrt;
         num_in  = it_req.num;
         den_in  = it_req.den;
         quo_in  = 64'd0;
         rem_in  = 33'd0;
         bit_in  = 64'd1 << 62;
         cnt_in  = it_req.sqrt ? 6'd31 : 6'd63;
      end else if (busy_ff) begin
         if (sqrt_ff) begin
            ge     = {1'b0, num_ff} >= trial;
            num_in = ge ? (num_ff - trial[63:0]) : num_ff;
            quo_in = ge ? ((quo_ff >> 1) + bit_ff) : (quo_ff >> 1);
            bit_in = bit_ff >> 2;
         end else begin
            ge     = !diff[34];
            rem_in = ge ? diff[32:0] : shifted[32:0];
            num_in = num_ff << 1;
            quo_in = {quo_ff[62:0], ge};
         end
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 6'd1;
         end
      end
   end

   assign it_rsp.done   = done_ff;
   assign it_rsp.result = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      sqrt_ff <= sqrt_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      bit_ff  <= bit_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

endmodule

// ===== rtl/core/gcr_back.sv =====
// back end: matrix stores, shared multiplier and the evaluate sequencer
// depends on gcr_pkg and drives gcr_iter through a request struct
module gcr_back import gcr_pkg::*; #(
   parameter int RIG_CAMERAS = RIG_CAMERAS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         error_mode,
   input  logic         q_valid,
   input  item_type     q_item,
   output logic         q_pop,
   output iter_req_type it_req,
   input  iter_rsp_type it_rsp,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [31:0]  rsp_residual,
   output logic         rsp_behind_camera
);

   localparam int MEM_ROWS = RIG_CAMERAS * ROW_COUNT;
   localparam int AW       = $clog2(MEM_ROWS);

   typedef enum logic [4:0] {
      S_IDLE, S_ROW_RD, S_ROW_LD, S_MUL, S_ACC, S_ROW_END,
      S_RP_GO, S_RP_WAIT, S_RP_MUL, S_RP_ADD,
      S_CS_MUL, S_CS_ACC, S_SQ1_GO, S_SQ1_WAIT, S_SQ2_GO, S_SQ2_WAIT,
      S_DOT_MUL, S_DOT_ACC, S_DV1_GO, S_DV1_WAIT, S_DV2_GO, S_DV2_WAIT,
      S_E_MUL, S_E_END, S_EMIT
   } state_type;

   state_type          state_ff, state_in;
   item_type           ent_ff, ent_in;
   logic [2:0]         pass_ff, pass_in;
   logic [2:0]         col_ff, col_in;
   row_type            row_ff, row_in;
   row_type [2:0]      pose_ff, pose_in;
   logic [2:0][31:0]   g_ff, g_in;
   logic [31:0]        p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic signed [49:0] acc_ff, acc_in;
   logic [63:0]        s1_ff, s1_in, s2_ff, s2_in;
   logic [32:0]        n1_ff, n1_in, n2_ff, n2_in;
   logic               neg_ff, neg_in;
   logic [63:0]        t_ff, t_in;
   logic [48:0]        sum_ff, sum_in;
   logic [31:0]        res_ff, res_in;
   logic               bc_ff, bc_in;
   logic signed [65:0] mul_ff, mul_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_residual_ff, rsp_residual_in;
   logic               rsp_behind_camera_ff, rsp_behind_camera_in;

   row_type            mem [MEM_ROWS];
   row_type            mem_rd_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_wa, mem_ra;
   logic [1:0]         cam_row;

   logic signed [32:0] mul_a, mul_b;
   logic [2:0][31:0]   vec;
   row_type            row_sel;
   logic [31:0]        sat_v;
   logic [49:0]        acc_mag;
   logic [31:0]        rp_p, rp_img, rp_pmag;
   logic signed [49:0] rp_q, rp_d;
   logic [49:0]        rp_m;
   logic [48:0]        rp_sum;
   logic [33:0]        two_n2;
   logic [16:0]        cos_c;
   logic               out_free;

   always_comb begin
      case (pass_ff)
         3'd3:    cam_row = 2'd2;
         3'd4:    cam_row = 2'd0;
         3'd5:    cam_row = 2'd1;
         default: cam_row = 2'd0;
      endcase
      mem_we = (state_ff == S_IDLE) && q_valid && (q_item.kind == KIND_CAM);
      mem_wa = AW'(32'(q_item.cam) * ROW_COUNT + 32'(q_item.row));
      mem_ra = AW'(32'(ent_ff.cam) * ROW_COUNT + 32'(cam_row));
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= {q_item.d, q_item.c, q_item.b, q_item.a};
      end
      mem_rd_ff <= mem[mem_ra];
   end

   always_comb begin
      vec     = (pass_ff < 3'd3) ? {ent_ff.c, ent_ff.b, ent_ff.a} : g_ff;
      row_sel = (pass_ff < 3'd3) ? pose_ff[pass_ff[1:0]] : mem_rd_ff;
      sat_v   = sat32(acc_ff);
      acc_mag = acc_ff[49] ? 50'(-acc_ff) : 50'(acc_ff);
      rp_p    = col_ff[0] ? p1_ff : p0_ff;
      rp_img  = col_ff[0] ? ent_ff.e : ent_ff.d;
      rp_pmag = rp_p[31] ? (~rp_p + 32'd1) : rp_p;
      rp_q    = rp_p[31] ? -$signed({2'b00, it_rsp.result[47:0]})
                         : $signed({2'b00, it_rsp.result[47:0]});
      rp_d    = $signed({{18{rp_img[31]}}, rp_img}) - rp_q;
      rp_m    = rp_d[49] ? 50'(-rp_d) : 50'(rp_d);
      rp_sum  = sum_ff + {1'b0, mul_ff[63:16]};
      two_n2  = {n2_ff, 1'b0};
      cos_c   = (it_rsp.result > 64'(ONE_Q16)) ? ONE_Q16 : it_rsp.result[16:0];
      out_free = !rsp_valid_ff || !rsp_stall;

      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MUL: begin
            mul_a = $signed({row_ff[col_ff[1:0]][31], row_ff[col_ff[1:0]]});
            mul_b = $signed({vec[col_ff[1:0]][31], vec[col_ff[1:0]]});
         end
         S_CS_MUL: begin
            case (col_ff)
               3'd0:    mul_a = $signed({p0_ff[31], p0_ff});
               3'd1:    mul_a = $signed({p1_ff[31], p1_ff});
               3'd2:    mul_a = $signed({p2_ff[31], p2_ff});
               3'd3:    mul_a = $signed({ent_ff.d[31], ent_ff.d});
               default: mul_a = $signed({ent_ff.e[31], ent_ff.e});
            endcase
            mul_b = mul_a;
         end
         S_DOT_MUL: begin
            mul_a = col_ff[0] ? $signed({p1_ff[31], p1_ff}) : $signed({p0_ff[31], p0_ff});
            mul_b = col_ff[0] ? $signed({ent_ff.e[31], ent_ff.e})
                              : $signed({ent_ff.d[31], ent_ff.d});
         end
         S_RP_MUL: begin
            mul_a = $signed({1'b0, t_ff[31:0]});
            mul_b = mul_a;
         end
         S_E_MUL: begin
            mul_a = $signed({15'd0, t_ff[17:0]});
            mul_b = mul_a;
         end
         default: begin
            mul_a = '0;
         end
      endcase
      mul_in = mul_a * mul_b;
   end

   always_comb begin
      state_in = state_ff;
      ent_in   = ent_ff;
      pass_in  = pass_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      pose_in  = pose_ff;
      g_in     = g_ff;
      p0_in    = p0_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      acc_in   = acc_ff;
      s1_in    = s1_ff;
      s2_in    = s2_ff;
      n1_in    = n1_ff;
      n2_in    = n2_ff;
      neg_in   = neg_ff;
      t_in     = t_ff;
      sum_in   = sum_ff;
      res_in   = res_ff;
      bc_in    = bc_ff;
      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      rsp_residual_in      = rsp_residual_ff;
      rsp_behind_camera_in = rsp_behind_camera_ff;
      q_pop    = 1'b0;
      it_req   = '0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               ent_in = q_item;
               case (q_item.kind)
                  KIND_POSE: begin
                     pose_in[q_item.row] = {q_item.d, q_item.c, q_item.b, q_item.a};
                  end
                  KIND_EVAL: begin
                     pass_in  = 3'd0;
                     state_in = S_ROW_RD;
                  end
                  KIND_NOCAM: begin
                     res_in   = RES_MAX;
                     bc_in    = 1'b0;
                     state_in = S_EMIT;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_ROW_RD: begin
            state_in = S_ROW_LD;
         end
         S_ROW_LD: begin
            row_in   = row_sel;
            acc_in   = $signed({{18{row_sel[3][31]}}, row_sel[3]});
            col_in   = 3'd0;
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in = acc_ff + 50'(mul_ff >>> 16);
            if (col_ff == 3'd2) begin
               state_in = S_ROW_END;
            end else begin
               col_in   = col_ff + 3'd1;
               state_in = S_MUL;
            end
         end
         S_ROW_END: begin
            pass_in  = pass_ff + 3'd1;
            state_in = S_ROW_RD;
            case (pass_ff)
               3'd3: begin
                  p2_in = sat_v;
                  if (sat_v[31] || (sat_v == 32'd0)) begin
                     res_in   = RES_MAX;
                     bc_in    = 1'b1;
                     state_in = S_EMIT;
                  end
               end
               3'd4: begin
                  p0_in = sat_v;
               end
               3'd5: begin
                  p1_in    = sat_v;
                  col_in   = 3'd0;
                  sum_in   = '0;
                  s1_in    = 64'd0;
                  s2_in    = 64'h1_0000_0000;
                  state_in = error_mode ? S_RP_GO : S_CS_MUL;
               end
               default: begin
                  g_in[pass_ff[1:0]] = sat_v;
               end
            endcase
         end
         S_RP_GO: begin
            it_req.start = 1'b1;
            it_req.num   = {16'd0, rp_pmag, 16'd0};
            it_req.den   = {1'b0, p2_ff};
            state_in     = S_RP_WAIT;
         end
         S_RP_WAIT: begin
            if (it_rsp.done) begin
               if (|rp_m[49:32]) begin
                  res_in   = RES_MAX;
                  bc_in    = 1'b0;
                  state_in = S_EMIT;
               end else begin
                  t_in     = {32'd0, rp_m[31:0]};
                  state_in = S_RP_MUL;
               end
            end
         end
         S_RP_MUL: begin
            state_in = S_RP_ADD;
         end
         S_RP_ADD: begin
            sum_in = rp_sum;
            if (col_ff[0]) begin
               res_in   = (|rp_sum[48:32]) ? RES_MAX : rp_sum[31:0];
               bc_in    = 1'b0;
               state_in = S_EMIT;
            end else begin
               col_in   = 3'd1;
               state_in = S_RP_GO;
            end
         end
         S_CS_MUL: begin
            state_in = S_CS_ACC;
         end
         S_CS_ACC: begin
            if (col_ff < 3'd3) begin
               s1_in = s1_ff + mul_ff[63:0];
            end else begin
               s2_in = s2_ff + mul_ff[63:0];
            end
            if (col_ff == 3'd4) begin
               state_in = S_SQ1_GO;
            end else begin
               col_in   = col_ff + 3'd1;
               state_in = S_CS_MUL;
            end
         end
         S_SQ1_GO: begin
            it_req.start = 1'b1;
            it_req.sqrt  = 1'b1;
            it_req.num   = s1_ff;
            state_in     = S_SQ1_WAIT;
         end
         S_SQ1_WAIT: begin
            if (it_rsp.done) begin
               n1_in    = (it_rsp.result[32:0] == 33'd0) ? 33'd1 : it_rsp.result[32:0];
               state_in = S_SQ2_GO;
            end
         end
         S_SQ2_GO: begin
            it_req.start = 1'b1;
            it_req.sqrt  = 1'b1;
            it_req.num   = s2_ff;
            state_in     = S_SQ2_WAIT;
         end
         S_SQ2_WAIT: begin
            if (it_rsp.done) begin
               n2_in    = it_rsp.result[32:0];
               acc_in   = $signed({{18{p2_ff[31]}}, p2_ff});
               col_in   = 3'd0;
               state_in = S_DOT_MUL;
            end
         end
         S_DOT_MUL: begin
            state_in = S_DOT_ACC;
         end
         S_DOT_ACC: begin
            acc_in = acc_ff + 50'(mul_ff >>> 16);
            if (col_ff[0]) begin
               state_in = S_DV1_GO;
            end else begin
               col_in   = 3'd1;
               state_in = S_DOT_MUL;
            end
         end
         S_DV1_GO: begin
            neg_in       = acc_ff[49];
            it_req.start = 1'b1;
            it_req.num   = {acc_mag[47:0], 16'd0};
            it_req.den   = n1_ff;
            state_in     = S_DV1_WAIT;
         end
         S_DV1_WAIT: begin
            if (it_rsp.done) begin
               t_in     = (it_rsp.result > 64'(two_n2)) ? 64'(two_n2) : it_rsp.result;
               state_in = S_DV2_GO;
            end
         end
         S_DV2_GO: begin
            it_req.start = 1'b1;
            it_req.num   = {t_ff[47:0], 16'd0};
            it_req.den   = n2_ff;
            state_in     = S_DV2_WAIT;
         end
         S_DV2_WAIT: begin
            if (it_rsp.done) begin
               t_in     = neg_ff ? 64'(18'(ONE_Q16) + 18'(cos_c))
                                 : 64'(18'(ONE_Q16) - 18'(cos_c));
               state_in = S_E_MUL;
            end
         end
         S_E_MUL: begin
            state_in = S_E_END;
         end
         S_E_END: begin
            res_in   = mul_ff[47:16];
            bc_in    = 1'b0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_residual_in      = res_ff;
               rsp_behind_camera_in = bc_ff;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pose_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pose_ff      <= pose_in;
      end
      ent_in_hold: begin
      end
      ent_ff  <= ent_in;
      pass_ff <= pass_in;
      col_ff  <= col_in;
      row_ff  <= row_in;
      g_ff    <= g_in;
      p0_ff   <= p0_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      acc_ff  <= acc_in;
      s1_ff   <= s1_in;
      s2_ff   <= s2_in;
      n1_ff   <= n1_in;
      n2_ff   <= n2_in;
      neg_ff  <= neg_in;
      t_ff    <= t_in;
      sum_ff  <= sum_in;
      res_ff  <= res_in;
      bc_ff   <= bc_in;
      mul_ff  <= mul_in;
      rsp_residual_ff      <= rsp_residual_in;
      rsp_behind_camera_ff <= rsp_behind_camera_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_residual      = rsp_residual_ff;
   assign rsp_behind_camera = rsp_behind_camera_ff;

`ifndef SYNTHESIS
   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      it_rsp.done |-> (state_ff == S_RP_WAIT || state_ff == S_SQ1_WAIT ||
                       state_ff == S_SQ2_WAIT || state_ff == S_DV1_WAIT ||
                       state_ff == S_DV2_WAIT))
      else $error("iterative unit finished with no one waiting");

   a_emit_lands: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && out_free) |=> rsp_valid_ff)
      else $error("result lost on its way to the output register");

   a_behind_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_behind_camera_ff) |-> (rsp_residual_ff == RES_MAX))
      else $error("behind camera without saturated residual");
`endif

endmodule

// ===== verif/generalized_camera_residual_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for generalized_camera_residual: directed table then random traffic
// predicts residuals with its own fixed-point pose/camera model; depends on gcr_pkg and the rtl
module generalized_camera_residual_tb;
   import gcr_pkg::*;

   localparam logic [1:0] OP_NONE = 2'd3;
   localparam logic [1:0] ROW_NONE = 2'd3;
   localparam logic [31:0] Q_ONE = 32'h0001_0000;
   localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] S_MIN = 32'h8000_0000;
   localparam int CAMS = RIG_CAMERAS_DEF;

   typedef struct {
      logic [1:0]  op;
      logic [2:0]  cam;
      logic [1:0]  row;
      logic [31:0] a, b, c, d, e;
      bit          typed;
      logic [31:0] res;
      logic        behind;
   } stim_row_type;

   typedef struct {
      logic [31:0] res;
      logic        behind;
   } score_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [2:0]  req_camera_index = '0;
   logic [1:0]  req_row_index = '0;
   logic [31:0] req_value_a = '0, req_value_b = '0, req_value_c = '0;
   logic [31:0] req_value_d = '0, req_value_e = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_residual;
   logic        rsp_behind_camera;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_error_mode = 1'b0;

   // predictor state
   logic signed [31:0] pose_q[12];
   logic signed [31:0] cam_q[CAMS][12];
   logic [2:0]         rows_loaded[CAMS];
   bit                 mode_reproj;

   score_type    pending_scores[$];
   stim_row_type table_rows[$];
   int unsigned  mismatches = 0;
   int unsigned  n_eval = 0, n_load = 0, n_behind = 0, n_sat = 0, n_cos = 0;
   bit           gaps_on = 1'b1;
   int unsigned  stall_left = 0;

   generalized_camera_residual dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return S_MAX;
      if (v < -64'sd2147483648) return S_MIN;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] apply_row(logic signed [31:0] r0, r1, r2, r3,
                                                    logic signed [31:0] x, y, z);
      longint s;
      s = ((longint'(r0) * longint'(x)) >>> 16) + ((longint'(r1) * longint'(y)) >>> 16) +
          ((longint'(r2) * longint'(z)) >>> 16) + longint'(r3);
      return clamp32(s);
   endfunction

   function automatic logic [63:0] root64(logic [63:0] v);
      logic [63:0] r, bt;
      r = 0;
      bt = 64'h1 << 62;
      while (bt > v) bt = bt >> 2;
      while (bt != 0) begin
         if (v >= r + bt) begin
            v = v - (r + bt);
            r = (r >> 1) + bt;
         end else begin
            r = r >> 1;
         end
         bt = bt >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] sq(logic signed [31:0] v);
      longint w;
      w = v;
      return w * w;
   endfunction

   function automatic logic [31:0] reproj_err(logic signed [31:0] p0, p1, p2, x, y);
      longint q, d;
      logic [63:0] m, sum;
      logic signed [31:0] num[2], img[2];
      num[0] = p0; num[1] = p1; img[0] = x; img[1] = y;
      sum = 0;
      for (int k = 0; k < 2; k++) begin
         q = (longint'(num[k]) * 65536) / longint'(p2);
         d = longint'(img[k]) - q;
         m = (d < 0) ? -d : d;
         if (m >= 64'h1_0000_0000) return RES_MAX;
         sum = sum + ((m * m) >> 16);
      end
      return (sum > 64'hFFFF_FFFF) ? RES_MAX : sum[31:0];
   endfunction

   function automatic logic [31:0] cosine_err(logic signed [31:0] p0, p1, p2, x, y);
      logic [63:0] n1, n2, mag, t, c, e;
      longint dot;
      n1 = root64(sq(p0) + sq(p1) + sq(p2));
      n2 = root64(sq(x) + sq(y) + 64'h1_0000_0000);
      dot = ((longint'(p0) * longint'(x)) >>> 16) + ((longint'(p1) * longint'(y)) >>> 16) +
            longint'(p2);
      mag = (dot < 0) ? -dot : dot;
      if (n1 == 0) n1 = 1;
      t = (mag << 16) / n1;
      if (t > 2 * n2) t = 2 * n2;
      c = (t << 16) / n2;
      if (c > 65536) c = 65536;
      e = (dot < 0) ? 65536 + c : 65536 - c;
      return 32'((e * e) >> 16);
   endfunction

   // updates predictor state, returns 1 when a score is produced
   function automatic bit predict(stim_row_type s, output score_type o);
      logic signed [31:0] g0, g1, g2, p0, p1, p2;
      logic signed [31:0] t[12];
      o.res = RES_MAX;
      o.behind = 1'b0;
      if (s.op == OP_LOAD_POSE || s.op == OP_LOAD_CAM) begin
         if (s.row == ROW_NONE) return 0;
         if (s.op == OP_LOAD_POSE) begin
            pose_q[s.row*4] = s.a; pose_q[s.row*4+1] = s.b;
            pose_q[s.row*4+2] = s.c; pose_q[s.row*4+3] = s.d;
         end else begin
            cam_q[s.cam][s.row*4] = s.a; cam_q[s.cam][s.row*4+1] = s.b;
            cam_q[s.cam][s.row*4+2] = s.c; cam_q[s.cam][s.row*4+3] = s.d;
            rows_loaded[s.cam][s.row] = 1'b1;
         end
         return 0;
      end
      if (s.op != OP_EVALUATE) return 0;
      g0 = apply_row(pose_q[0], pose_q[1], pose_q[2], pose_q[3], s.a, s.b, s.c);
      g1 = apply_row(pose_q[4], pose_q[5], pose_q[6], pose_q[7], s.a, s.b, s.c);
      g2 = apply_row(pose_q[8], pose_q[9], pose_q[10], pose_q[11], s.a, s.b, s.c);
      t = cam_q[s.cam];
      p2 = apply_row(t[8], t[9], t[10], t[11], g0, g1, g2);
      if (p2 <= 0) begin
         o.behind = 1'b1;
         return 1;
      end
      p0 = apply_row(t[0], t[1], t[2], t[3], g0, g1, g2);
      p1 = apply_row(t[4], t[5], t[6], t[7], g0, g1, g2);
      o.res = mode_reproj ? reproj_err(p0, p1, p2, s.d, s.e) : cosine_err(p0, p1, p2, s.d, s.e);
      return 1;
   endfunction

   function automatic stim_row_type mk(logic [1:0] op, logic [2:0] cam, logic [1:0] row,
                                       logic [31:0] a, b, c, d, e, bit typed = 0,
                                       logic [31:0] res = '0, logic behind = 0);
      stim_row_type s;
      s.op = op; s.cam = cam; s.row = row;
      s.a = a; s.b = b; s.c = c; s.d = d; s.e = e;
      s.typed = typed; s.res = res; s.behind = behind;
      return s;
   endfunction

   function automatic void add_row(stim_row_type s);
      table_rows = {table_rows, s};
   endfunction

   function automatic logic [31:0] rand_q();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? S_MAX : S_MIN;
         2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
         default: return $urandom_range(0, 524288) - 262144;
      endcase
   endfunction

   function automatic int unsigned gap_len();
      if (!gaps_on) return 0;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return 0;
         9: return $urandom_range(10, 60);
         default: return $urandom_range(1, 3);
      endcase
   endfunction

   task automatic send(stim_row_type s);
      score_type o;
      req_valid <= 1'b1;
      req_opcode <= s.op;
      req_camera_index <= s.cam;
      req_row_index <= s.row;
      req_value_a <= s.a; req_value_b <= s.b; req_value_c <= s.c;
      req_value_d <= s.d; req_value_e <= s.e;
      do @(posedge clock); while (req_stall);
      if (predict(s, o)) begin
         if (s.typed) begin
            o.res = s.res;
            o.behind = s.behind;
         end
         pending_scores = {pending_scores, o};
         n_eval++;
         if (!mode_reproj) n_cos++;
         if (o.behind) n_behind++;
         else if (o.res == RES_MAX) n_sat++;
      end else begin
         n_load++;
      end
      begin
         int unsigned g;
         g = gap_len();
         if (g != 0) begin
            req_valid <= 1'b0;
            repeat (g) @(posedge clock);
         end
      end
   endtask

   task automatic drain_and_set_mode(bit m);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_scores.size() != 0);
      repeat (10) @(posedge clock);
      csr_valid <= 1'b1;
      csr_error_mode <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mode_reproj = m;
   endtask

   task automatic random_phase(int unsigned count);
      stim_row_type s;
      int unsigned cam;
      for (int unsigned i = 0; i < count; i++) begin
         gaps_on = !(i >= 100 && i < 140);
         cam = $urandom_range(0, CAMS - 1);
         case ($urandom_range(0, 19))
            0: s = mk(OP_NONE, 3'($urandom), 2'($urandom), $urandom, $urandom, $urandom,
                      $urandom, $urandom);
            1: s = mk(2'($urandom_range(0, 1)), 3'($urandom), ROW_NONE, $urandom, $urandom,
                      $urandom, $urandom, $urandom);
            2, 3, 4: s = mk(OP_LOAD_POSE, 3'($urandom), 2'($urandom_range(0, 2)), rand_q(),
                            rand_q(), rand_q(), rand_q(), $urandom);
            5, 6, 7: s = mk(OP_LOAD_CAM, 3'(cam), 2'($urandom_range(0, 2)), rand_q(),
                            rand_q(), rand_q(), rand_q(), $urandom);
            default: begin
               if (rows_loaded[cam] != 3'b111)
                  s = mk(OP_LOAD_CAM, 3'(cam), 2'($urandom_range(0, 2)), rand_q(), rand_q(),
                         rand_q(), rand_q(), $urandom);
               else
                  s = mk(OP_EVALUATE, 3'(cam), 2'($urandom), rand_q(), rand_q(), rand_q(),
                         rand_q(), rand_q());
            end
         endcase
         send(s);
      end
      gaps_on = 1'b1;
   endtask

   // result side backpressure
   always @(posedge clock) begin
      if (reset || !gaps_on) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left == 0) begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 3);
      end else begin
         stall_left <= stall_left - 1;
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_scores.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer: residual %h behind %b", rsp_residual,
                        rsp_behind_camera);
         end else begin
            score_type x;
            x = pending_scores.pop_front();
            if (x.res !== rsp_residual || x.behind !== rsp_behind_camera) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: residual exp %h got %h, behind exp %b got %b",
                           x.res, rsp_residual, x.behind, rsp_behind_camera);
            end
         end
      end
   end

   initial begin
      #(20_000_000);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      mode_reproj = 1'b1;
      foreach (pose_q[i]) pose_q[i] = '0;
      foreach (cam_q[i, j]) cam_q[i][j] = '0;
      foreach (rows_loaded[i]) rows_loaded[i] = '0;

      add_row(mk(OP_LOAD_CAM, 0, 0, Q_ONE, 0, 0, 0, 0));
      add_row(mk(OP_LOAD_CAM, 0, 1, 0, Q_ONE, 0, 0, 0));
      add_row(mk(OP_LOAD_CAM, 0, 2, 0, 0, Q_ONE, 0, 0));
      add_row(mk(OP_LOAD_POSE, 0, 0, 0, 0, 0, 0, 0));
      add_row(mk(OP_LOAD_POSE, 0, 1, 0, 0, 0, 0, 0));
      add_row(mk(OP_LOAD_POSE, 0, 2, 0, 0, 0, 0, 0));
      // zero pose puts every point at depth zero
      add_row(mk(OP_EVALUATE, 0, 0, Q_ONE, Q_ONE, Q_ONE, 0, 0, 1, RES_MAX, 1));
      add_row(mk(OP_LOAD_POSE, 0, 0, Q_ONE, 0, 0, 0, 0));
      add_row(mk(OP_LOAD_POSE, 0, 1, 0, Q_ONE, 0, 0, 0));
      add_row(mk(OP_LOAD_POSE, 0, 2, 0, 0, Q_ONE, 0, 0));
      add_row(mk(OP_EVALUATE, 0, 0, 0, 0, Q_ONE, 0, 0, 1, 32'h0, 0));
      add_row(mk(OP_EVALUATE, 0, 1, 0, 0, -Q_ONE, 0, 0, 1, RES_MAX, 1));
      add_row(mk(OP_LOAD_POSE, 7, ROW_NONE, '1, '1, '1, '1, '1));
      add_row(mk(OP_NONE, 7, ROW_NONE, '1, '1, '1, '1, '1));
      add_row(mk(OP_LOAD_CAM, 7, ROW_NONE, '1, '1, '1, '1, '1));
      add_row(mk(OP_LOAD_CAM, 7, 0, S_MAX, S_MIN, 0, S_MAX, '1));
      add_row(mk(OP_LOAD_CAM, 7, 1, S_MIN, S_MAX, 0, S_MIN, 0));
      add_row(mk(OP_LOAD_CAM, 7, 2, 0, 0, Q_ONE, S_MAX, 0));
      add_row(mk(OP_EVALUATE, 7, 2, S_MAX, S_MIN, S_MAX, S_MAX, S_MIN));
      add_row(mk(OP_EVALUATE, 7, 0, 0, 0, 0, 0, 0));
      add_row(mk(OP_EVALUATE, 0, 0, Q_ONE, 2 * Q_ONE, 4 * Q_ONE, Q_ONE / 4, Q_ONE / 2));
      add_row(mk(OP_EVALUATE, 0, 0, -Q_ONE, 0, Q_ONE, 4 * Q_ONE, 0));
      add_row(mk(OP_EVALUATE, 0, 0, S_MAX, S_MAX, 1, S_MIN, S_MAX));
      add_row(mk(OP_EVALUATE, 0, 0, 32'h1, 32'hFFFF_FFFF, 32'h1, 32'h1, 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[i]) send(table_rows[i]);
      drain_and_set_mode(1'b0);
      foreach (table_rows[i]) send(table_rows[i]);
      random_phase(250);
      drain_and_set_mode(1'b1);
      random_phase(250);
      drain_and_set_mode(1'b0);
      random_phase(200);

      req_valid <= 1'b0;
      do @(posedge clock); while (pending_scores.size() != 0);
      repeat (300) @(posedge clock);

      $display("covered %0d evaluates (%0d in cosine mode, %0d behind camera, %0d saturated)",
               n_eval, n_cos, n_behind, n_sat);
      $display("and %0d loads or ignored items; %0d mismatches", n_load, mismatches);
      if (mismatches == 0 && pending_scores.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/gcr_pkg.sv
rtl/core/gcr_front.sv
rtl/core/gcr_iter.sv
rtl/core/gcr_back.sv
rtl/core/generalized_camera_residual.sv
verif/generalized_camera_residual_tb.sv
